// ===== rtl/nhq_pkg.sv =====
// ----------------------------------------------------------------------------
// nhq_pkg: shared types and constants
// Item types, action and result codes, and register layout for the NVMe
// host queue pair engine.
// ----------------------------------------------------------------------------
`default_nettype none

package nhq_pkg;

  localparam int unsigned ADMIN_QUEUE_DEPTH = 32;
  localparam int unsigned IO_QUEUE_DEPTH    = 32;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // register indexes
  localparam logic [1:0] REG_STRIDE    = 2'd0;
  localparam logic [1:0] REG_NAMESPACE = 2'd1;
  localparam logic [1:0] REG_BLOCKS    = 2'd2;

  // input actions
  localparam logic [2:0] ACT_ADMIN_SUBMIT = 3'd0;
  localparam logic [2:0] ACT_IO_READ      = 3'd1;
  localparam logic [2:0] ACT_IO_WRITE     = 3'd2;
  localparam logic [2:0] ACT_ADMIN_CPL    = 3'd3;
  localparam logic [2:0] ACT_IO_CPL       = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_SUBMITTED = 3'd0;
  localparam logic [2:0] KIND_REJECTED  = 3'd1;
  localparam logic [2:0] KIND_OK        = 3'd2;
  localparam logic [2:0] KIND_ERROR     = 3'd3;
  localparam logic [2:0] KIND_PENDING   = 3'd4;

  localparam logic [19:0] DB_BASE     = 20'h01000;
  localparam logic [9:0]  STATUS_MASK = 10'h3FF;
  localparam logic [7:0]  OPC_READ    = 8'h02;
  localparam logic [7:0]  OPC_WRITE   = 8'h01;

  // doorbell indexes: 2*qid for submission, 2*qid+1 for completion
  localparam logic [1:0] DB_ADMIN_SQ = 2'd0;
  localparam logic [1:0] DB_ADMIN_CQ = 2'd1;
  localparam logic [1:0] DB_IO_SQ    = 2'd2;
  localparam logic [1:0] DB_IO_CQ    = 2'd3;

  typedef struct packed {
    logic [3:0]  doorbell_stride_field;
    logic [31:0] namespace_id;
    logic [31:0] block_count;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  opcode;
    logic [31:0] admin_namespace;
    logic [63:0] data_addr;
    logic [31:0] block_number;
    logic [31:0] dword10;
    logic [31:0] dword11;
    logic [15:0] cqe_status;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  slot_index;
    logic [15:0] command_id;
    logic [7:0]  sqe_opcode;
    logic [31:0] sqe_namespace;
    logic [63:0] sqe_data_addr;
    logic [31:0] sqe_dword10;
    logic [31:0] sqe_dword11;
    logic [19:0] doorbell_offset;
    logic [4:0]  doorbell_value;
  } out_item_t;

  // doorbell register offset: base + index * (4 << stride), 20-bit wrap
  function automatic logic [19:0] bell_offset(input logic [1:0] index,
                                              input logic [3:0] stride_field);
    logic [19:0] idx;
    idx = 20'(index);
    return DB_BASE + (idx << (5'(stride_field) + 5'd2));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nhq_cfg.sv =====
// ----------------------------------------------------------------------------
// nhq_cfg: configuration registers
// APB-style register file holding doorbell stride, namespace and block count.
// ----------------------------------------------------------------------------
`default_nettype none

module nhq_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [nhq_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [nhq_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [nhq_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                     pready,
  output nhq_pkg::cfg_t                            cfg
);

  logic        wr_en;
  logic [1:0]  reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.doorbell_stride_field <= 4'd0;
      cfg.namespace_id          <= 32'd1;
      cfg.block_count           <= 32'd0;
    end else if (wr_en) begin
      unique case (reg_index)
        nhq_pkg::REG_STRIDE:    cfg.doorbell_stride_field <= pwdata[3:0];
        nhq_pkg::REG_NAMESPACE: cfg.namespace_id          <= pwdata;
        nhq_pkg::REG_BLOCKS:    cfg.block_count           <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      nhq_pkg::REG_STRIDE:    prdata = 32'(cfg.doorbell_stride_field);
      nhq_pkg::REG_NAMESPACE: prdata = cfg.namespace_id;
      nhq_pkg::REG_BLOCKS:    prdata = cfg.block_count;
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/nhq_core.sv =====
// ----------------------------------------------------------------------------
// nhq_core: input register, queue pointers and entry forming
// Holds one item, forms its result from the queue state in one pass and
// advances tails, heads, phases and the command id when the result moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module nhq_core #(
  parameter int unsigned ADMIN_QUEUE_DEPTH = nhq_pkg::ADMIN_QUEUE_DEPTH,
  parameter int unsigned IO_QUEUE_DEPTH    = nhq_pkg::IO_QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  nhq_pkg::cfg_t            cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  nhq_pkg::in_item_t        in_item,
  output logic                     res_valid,
  output nhq_pkg::out_item_t       res_item,
  input  wire logic                res_take
);

  localparam int unsigned A_W = $clog2(ADMIN_QUEUE_DEPTH);
  localparam int unsigned I_W = $clog2(IO_QUEUE_DEPTH);
  localparam logic [A_W-1:0] A_LAST = A_W'(ADMIN_QUEUE_DEPTH - 1);
  localparam logic [I_W-1:0] I_LAST = I_W'(IO_QUEUE_DEPTH - 1);

  logic                 stage_valid;
  nhq_pkg::in_item_t    stage;
  logic                 advance;

  logic [A_W-1:0] admin_tail, admin_tail_next, admin_tail_inc;
  logic [A_W-1:0] admin_head, admin_head_next, admin_head_inc;
  logic           admin_phase, admin_phase_next;
  logic [I_W-1:0] io_tail, io_tail_next, io_tail_inc;
  logic [I_W-1:0] io_head, io_head_next, io_head_inc;
  logic           io_phase, io_phase_next;
  logic [15:0]    command_id, command_id_next;

  logic           known;
  logic           in_range;
  logic           is_admin;
  logic           phase_match;
  logic [9:0]     status_code;

  assign advance  = stage_valid && res_take;
  assign in_ready = !stage_valid || res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= in_item;
    end
  end

  assign admin_tail_inc = (admin_tail == A_LAST) ? '0 : admin_tail + 1'b1;
  assign admin_head_inc = (admin_head == A_LAST) ? '0 : admin_head + 1'b1;
  assign io_tail_inc    = (io_tail == I_LAST) ? '0 : io_tail + 1'b1;
  assign io_head_inc    = (io_head == I_LAST) ? '0 : io_head + 1'b1;

  assign known       = stage.action <= nhq_pkg::ACT_IO_CPL;
  assign in_range    = stage.block_number < cfg.block_count;
  assign is_admin    = stage.action == nhq_pkg::ACT_ADMIN_CPL;
  assign phase_match = stage.cqe_status[0] == (is_admin ? admin_phase : io_phase);
  assign status_code = stage.cqe_status[10:1] & nhq_pkg::STATUS_MASK;
  assign res_valid   = stage_valid && known;

  always_comb begin
    admin_tail_next  = admin_tail;
    admin_head_next  = admin_head;
    admin_phase_next = admin_phase;
    io_tail_next     = io_tail;
    io_head_next     = io_head;
    io_phase_next    = io_phase;
    command_id_next  = command_id;
    res_item         = '0;

    unique case (stage.action)
      nhq_pkg::ACT_ADMIN_SUBMIT: begin
        command_id_next          = command_id + 16'd1;
        admin_tail_next          = admin_tail_inc;
        res_item.kind            = nhq_pkg::KIND_SUBMITTED;
        res_item.slot_index      = 5'(admin_tail);
        res_item.command_id      = command_id;
        res_item.sqe_opcode      = stage.opcode;
        res_item.sqe_namespace   = stage.admin_namespace;
        res_item.sqe_data_addr   = stage.data_addr;
        res_item.sqe_dword10     = stage.dword10;
        res_item.sqe_dword11     = stage.dword11;
        res_item.doorbell_offset = nhq_pkg::bell_offset(nhq_pkg::DB_ADMIN_SQ,
                                                        cfg.doorbell_stride_field);
        res_item.doorbell_value  = 5'(admin_tail_inc);
      end
      nhq_pkg::ACT_IO_READ, nhq_pkg::ACT_IO_WRITE: begin
        if (!in_range) begin
          res_item.kind = nhq_pkg::KIND_REJECTED;
        end else begin
          command_id_next          = command_id + 16'd1;
          io_tail_next             = io_tail_inc;
          res_item.kind            = nhq_pkg::KIND_SUBMITTED;
          res_item.slot_index      = 5'(io_tail);
          res_item.command_id      = command_id;
          res_item.sqe_opcode      = (stage.action == nhq_pkg::ACT_IO_READ) ?
                                     nhq_pkg::OPC_READ : nhq_pkg::OPC_WRITE;
          res_item.sqe_namespace   = cfg.namespace_id;
          res_item.sqe_data_addr   = stage.data_addr;
          res_item.sqe_dword10     = stage.block_number;
          res_item.doorbell_offset = nhq_pkg::bell_offset(nhq_pkg::DB_IO_SQ,
                                                          cfg.doorbell_stride_field);
          res_item.doorbell_value  = 5'(io_tail_inc);
        end
      end
      nhq_pkg::ACT_ADMIN_CPL: begin
        if (!phase_match) begin
          res_item.kind = nhq_pkg::KIND_PENDING;
        end else begin
          admin_head_next = admin_head_inc;
          // flip the expected phase when the head wraps
          if (admin_head_inc == '0) admin_phase_next = !admin_phase;
          res_item.kind = (status_code != '0) ? nhq_pkg::KIND_ERROR : nhq_pkg::KIND_OK;
          res_item.doorbell_offset = nhq_pkg::bell_offset(nhq_pkg::DB_ADMIN_CQ,
                                                          cfg.doorbell_stride_field);
          res_item.doorbell_value  = 5'(admin_head_inc);
        end
      end
      nhq_pkg::ACT_IO_CPL: begin
        if (!phase_match) begin
          res_item.kind = nhq_pkg::KIND_PENDING;
        end else begin
          io_head_next = io_head_inc;
          if (io_head_inc == '0) io_phase_next = !io_phase;
          res_item.kind = (status_code != '0) ? nhq_pkg::KIND_ERROR : nhq_pkg::KIND_OK;
          res_item.doorbell_offset = nhq_pkg::bell_offset(nhq_pkg::DB_IO_CQ,
                                                          cfg.doorbell_stride_field);
          res_item.doorbell_value  = 5'(io_head_inc);
        end
      end
      default: ;  // undefined actions: drop without a result
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      admin_tail  <= '0;
      admin_head  <= '0;
      admin_phase <= 1'b1;
      io_tail     <= '0;
      io_head     <= '0;
      io_phase    <= 1'b1;
      command_id  <= 16'd1;
    end else if (advance) begin
      admin_tail  <= admin_tail_next;
      admin_head  <= admin_head_next;
      admin_phase <= admin_phase_next;
      io_tail     <= io_tail_next;
      io_head     <= io_head_next;
      io_phase    <= io_phase_next;
      command_id  <= command_id_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nhq_out.sv =====
// ----------------------------------------------------------------------------
// nhq_out: result register
// Holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nhq_out (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                res_valid,
  input  nhq_pkg::out_item_t       res_item,
  output logic                     res_take,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output nhq_pkg::out_item_t       out_item
);

  // free when empty or the held item leaves this cycle
  assign res_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_item <= res_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nvme_host_queue_pair_engine_unit.sv =====
// ----------------------------------------------------------------------------
// nvme_host_queue_pair_engine_unit: NVMe host admin and I/O queue pair engine
// Forms submission entries and doorbell writes, tracks completion heads and
// phase tags for one admin and one I/O queue pair.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the result side drains and passes
// it from the input register, where the queue pointers are read and updated,
// to the result register. Both registers can hold an item while the consumer
// stalls, so input keeps flowing as long as the result side drains. Unknown
// actions are consumed without a result.
// Registers: 0x0 doorbell stride field, 0x4 namespace id, 0x8 block count.
`default_nettype none

module nvme_host_queue_pair_engine_unit #(
  parameter int unsigned ADMIN_QUEUE_DEPTH = nhq_pkg::ADMIN_QUEUE_DEPTH,
  parameter int unsigned IO_QUEUE_DEPTH    = nhq_pkg::IO_QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nhq_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [nhq_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [nhq_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  nhq_pkg::in_item_t                    in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output nhq_pkg::out_item_t                   out_item
);

  nhq_pkg::cfg_t       cfg;
  logic                res_valid;
  logic                res_take;
  nhq_pkg::out_item_t  res_item;

  nhq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nhq_core #(
    .ADMIN_QUEUE_DEPTH (ADMIN_QUEUE_DEPTH),
    .IO_QUEUE_DEPTH    (IO_QUEUE_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_take  (res_take)
  );

  nhq_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_take  (res_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== tb/sv/nvme_host_queue_pair_engine_unit_test.sv =====
// ----------------------------------------------------------------------------
// nvme_host_queue_pair_engine_unit_test: queue pair engine testbench
// Writes the doorbell stride, namespace and block count registers over the
// APB port, then drives directed and random submit and completion items
// through the valid/ready input while the output side stalls at random.
// An in-bench model of the admin and I/O queue pointers, phase tags and
// command ids predicts every result, and each result is checked field by
// field.
// ----------------------------------------------------------------------------
`default_nettype none

module nvme_host_queue_pair_engine_unit_test;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned HOLD_CYCLES  = 90;
  localparam int unsigned SETTLE       = 6;
  localparam logic [2:0]  ACT_FIRST_UNUSED = 3'd5;
  localparam logic [2:0]  ACT_LAST_UNUSED  = 3'd7;

  typedef struct {
    nhq_pkg::in_item_t it;
    bit                tag_hit;  // force the phase tag to the expected value at launch
  } backlog_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [nhq_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [nhq_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [nhq_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  logic               in_valid  = 1'b0;
  logic               in_ready;
  nhq_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  nhq_pkg::out_item_t out_item;

  // engine state as predicted
  int unsigned adm_tail, adm_head, io_tail, io_head;
  logic        adm_phase, io_phase;
  logic [15:0] pred_cid;
  logic [3:0]  cfg_stride;
  logic [31:0] cfg_nsid;
  logic [31:0] cfg_blocks;

  backlog_entry_t     cmd_backlog[$];
  nhq_pkg::out_item_t due_results[$];
  backlog_entry_t     next_cmd;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_asked    = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int unsigned errors        = 0;

  nvme_host_queue_pair_engine_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    adm_tail   = 0;
    adm_head   = 0;
    io_tail    = 0;
    io_head    = 0;
    adm_phase  = 1'b1;
    io_phase   = 1'b1;
    pred_cid   = 16'd1;
    cfg_stride = 4'd0;
    cfg_nsid   = 32'd1;
    cfg_blocks = 32'd0;
  end

  function automatic logic [19:0] doorbell_at(input logic [1:0] idx);
    logic [63:0] step;
    step = 64'd4 << cfg_stride;
    return 20'(64'(nhq_pkg::DB_BASE) + 64'(idx) * step);
  endfunction

  // advance the predicted queue state by one accepted item
  task automatic advance_queue_pair(input nhq_pkg::in_item_t c);
    nhq_pkg::out_item_t r;
    logic [9:0]         code;
    logic               is_admin;
    logic               tag_ok;
    r = '0;
    case (c.action)
      nhq_pkg::ACT_ADMIN_SUBMIT, nhq_pkg::ACT_IO_READ, nhq_pkg::ACT_IO_WRITE: begin
        if (c.action != nhq_pkg::ACT_ADMIN_SUBMIT && c.block_number >= cfg_blocks) begin
          r.kind = nhq_pkg::KIND_REJECTED;
        end else begin
          r.kind          = nhq_pkg::KIND_SUBMITTED;
          r.command_id    = pred_cid;
          pred_cid        = pred_cid + 16'd1;
          r.sqe_data_addr = c.data_addr;
          if (c.action == nhq_pkg::ACT_ADMIN_SUBMIT) begin
            r.slot_index      = 5'(adm_tail);
            adm_tail          = (adm_tail + 1) % nhq_pkg::ADMIN_QUEUE_DEPTH;
            r.sqe_opcode      = c.opcode;
            r.sqe_namespace   = c.admin_namespace;
            r.sqe_dword10     = c.dword10;
            r.sqe_dword11     = c.dword11;
            r.doorbell_offset = doorbell_at(nhq_pkg::DB_ADMIN_SQ);
            r.doorbell_value  = 5'(adm_tail);
          end else begin
            r.slot_index      = 5'(io_tail);
            io_tail           = (io_tail + 1) % nhq_pkg::IO_QUEUE_DEPTH;
            r.sqe_opcode      = (c.action == nhq_pkg::ACT_IO_READ) ?
                                nhq_pkg::OPC_READ : nhq_pkg::OPC_WRITE;
            r.sqe_namespace   = cfg_nsid;
            r.sqe_dword10     = c.block_number;
            r.doorbell_offset = doorbell_at(nhq_pkg::DB_IO_SQ);
            r.doorbell_value  = 5'(io_tail);
          end
        end
        due_results.push_back(r);
      end
      nhq_pkg::ACT_ADMIN_CPL, nhq_pkg::ACT_IO_CPL: begin
        is_admin = (c.action == nhq_pkg::ACT_ADMIN_CPL);
        tag_ok   = c.cqe_status[0] == (is_admin ? adm_phase : io_phase);
        if (!tag_ok) begin
          r.kind = nhq_pkg::KIND_PENDING;
        end else begin
          code   = c.cqe_status[10:1] & nhq_pkg::STATUS_MASK;
          r.kind = (code != '0) ? nhq_pkg::KIND_ERROR : nhq_pkg::KIND_OK;
          if (is_admin) begin
            adm_head = (adm_head + 1) % nhq_pkg::ADMIN_QUEUE_DEPTH;
            if (adm_head == 0) adm_phase = ~adm_phase;
            r.doorbell_offset = doorbell_at(nhq_pkg::DB_ADMIN_CQ);
            r.doorbell_value  = 5'(adm_head);
          end else begin
            io_head = (io_head + 1) % nhq_pkg::IO_QUEUE_DEPTH;
            if (io_head == 0) io_phase = ~io_phase;
            r.doorbell_offset = doorbell_at(nhq_pkg::DB_IO_CQ);
            r.doorbell_value  = 5'(io_head);
          end
        end
        due_results.push_back(r);
      end
      default: ;  // unused actions are swallowed without a result
    endcase
  endtask

  task automatic flag_mismatch(input string what);
    errors++;
    $display("MISMATCH @%0d: %s", cycle_count, what);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result(input nhq_pkg::out_item_t got);
    nhq_pkg::out_item_t want;
    if (due_results.size() == 0) begin
      flag_mismatch("result with nothing outstanding");
    end else begin
      want = due_results.pop_front();
      compare_field("kind",            64'(got.kind),            64'(want.kind));
      compare_field("slot_index",      64'(got.slot_index),      64'(want.slot_index));
      compare_field("command_id",      64'(got.command_id),      64'(want.command_id));
      compare_field("sqe_opcode",      64'(got.sqe_opcode),      64'(want.sqe_opcode));
      compare_field("sqe_namespace",   64'(got.sqe_namespace),   64'(want.sqe_namespace));
      compare_field("sqe_data_addr",   got.sqe_data_addr,        want.sqe_data_addr);
      compare_field("sqe_dword10",     64'(got.sqe_dword10),     64'(want.sqe_dword10));
      compare_field("sqe_dword11",     64'(got.sqe_dword11),     64'(want.sqe_dword11));
      compare_field("doorbell_offset", 64'(got.doorbell_offset), 64'(want.doorbell_offset));
      compare_field("doorbell_value",  64'(got.doorbell_value),  64'(want.doorbell_value));
    end
  endtask

  // input driver: predict on acceptance, then launch the next backlog item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) advance_queue_pair(in_item);
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = cmd_backlog.pop_front();
          if (next_cmd.tag_hit && next_cmd.it.action == nhq_pkg::ACT_ADMIN_CPL)
            next_cmd.it.cqe_status[0] = adm_phase;
          else if (next_cmd.tag_hit && next_cmd.it.action == nhq_pkg::ACT_IO_CPL)
            next_cmd.it.cqe_status[0] = io_phase;
          in_valid <= 1'b1;
          in_item  <= next_cmd.it;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_item);
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("nvme_host_queue_pair_engine_unit test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= nhq_pkg::APB_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      nhq_pkg::REG_STRIDE:    cfg_stride = val[3:0];
      nhq_pkg::REG_NAMESPACE: cfg_nsid   = val;
      nhq_pkg::REG_BLOCKS:    cfg_blocks = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // hold the sender until every expected result is back, then settle
  task automatic drain();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic backlog_entry_t make_cmd(input logic [2:0] act, input logic [7:0] opc,
                                              input logic [31:0] ns, input logic [63:0] addr,
                                              input logic [31:0] blk, input logic [31:0] d10,
                                              input logic [31:0] d11, input logic [15:0] sts);
    backlog_entry_t e;
    e.it.action          = act;
    e.it.opcode          = opc;
    e.it.admin_namespace = ns;
    e.it.data_addr       = addr;
    e.it.block_number    = blk;
    e.it.dword10         = d10;
    e.it.dword11         = d11;
    e.it.cqe_status      = sts;
    e.tag_hit            = 1'b0;
    return e;
  endfunction

  function automatic logic [2:0] pick_action();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return nhq_pkg::ACT_ADMIN_SUBMIT;
    if (r < 40) return nhq_pkg::ACT_IO_READ;
    if (r < 60) return nhq_pkg::ACT_IO_WRITE;
    if (r < 75) return nhq_pkg::ACT_ADMIN_CPL;
    if (r < 92) return nhq_pkg::ACT_IO_CPL;
    return 3'($urandom_range(ACT_LAST_UNUSED, ACT_FIRST_UNUSED));
  endfunction

  // random content; block numbers mostly in range, some at or past the end
  function automatic backlog_entry_t roll_command(input logic [2:0] act);
    backlog_entry_t e;
    int unsigned    pick;
    e = make_cmd(act, 8'($urandom), $urandom, {$urandom, $urandom}, $urandom,
                 $urandom, $urandom, 16'($urandom));
    pick = $urandom_range(99);
    if (cfg_blocks != 0 && pick < 75) e.it.block_number = $urandom_range(cfg_blocks - 1);
    else if (pick < 88) e.it.block_number = cfg_blocks;
    if ($urandom_range(1) == 0) e.it.cqe_status[10:1] = '0;
    e.tag_hit = ($urandom_range(99) < 85);
    return e;
  endfunction

  task automatic queue_random(input int unsigned n);
    repeat (n) cmd_backlog.push_back(roll_command(pick_action()));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // every I/O request is out of range with no blocks
    write_reg(nhq_pkg::REG_BLOCKS, 32'd0);
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_IO_READ, 8'h00, 32'h0, 64'h0, 32'h0,
                                   32'h0, 32'h0, 16'h0));
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_IO_WRITE, 8'hFF, 32'hFFFF_FFFF, '1,
                                   32'hFFFF_FFFF, 32'h0, 32'h0, 16'hFFFF));
    drain();

    write_reg(nhq_pkg::REG_STRIDE, 32'd15);
    write_reg(nhq_pkg::REG_NAMESPACE, 32'hFFFF_FFFF);
    write_reg(nhq_pkg::REG_BLOCKS, 32'hFFFF_FFFF);
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_ADMIN_SUBMIT, 8'hFF, 32'hFFFF_FFFF, '1,
                                   32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_ADMIN_SUBMIT, 8'h00, 32'h0, 64'h0,
                                   32'hFFFF_FFFF, 32'h0, 32'h0, 16'h0));
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_IO_READ, 8'hFF, 32'h1234_5678, 64'h0,
                                   32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0));
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_IO_WRITE, 8'h00, 32'h0, '1, 32'hFFFF_FFFF,
                                   32'h0, 32'h0, 16'h0));
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_IO_WRITE, 8'h5A, 32'h0, '1, 32'h0,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0));
    // wrong tag, then good tag with clean and full status
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_ADMIN_CPL, 8'h0, 32'h0, 64'h0, 32'h0,
                                   32'h0, 32'h0, 16'hFFFE));
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_ADMIN_CPL, 8'h0, 32'h0, 64'h0, 32'h0,
                                   32'h0, 32'h0, 16'h0001));
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_ADMIN_CPL, 8'h0, 32'h0, 64'h0, 32'h0,
                                   32'h0, 32'h0, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_IO_CPL, 8'h0, 32'h0, 64'h0, 32'h0,
                                   32'h0, 32'h0, 16'h0000));
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_IO_CPL, 8'h0, 32'h0, 64'h0, 32'h0,
                                   32'h0, 32'h0, 16'h07FF));
    // bits above the status field do not count as an error
    cmd_backlog.push_back(make_cmd(nhq_pkg::ACT_IO_CPL, 8'h0, 32'h0, 64'h0, 32'h0,
                                   32'h0, 32'h0, 16'hF801));
    for (int a = ACT_FIRST_UNUSED; a <= ACT_LAST_UNUSED; a++)
      cmd_backlog.push_back(make_cmd(3'(a), 8'hFF, 32'hFFFF_FFFF, '1, 32'h0, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 16'hFFFF));
    drain();

    // sender idles more lightly than the receiver
    write_reg(nhq_pkg::REG_STRIDE, 32'd3);
    write_reg(nhq_pkg::REG_NAMESPACE, $urandom);
    write_reg(nhq_pkg::REG_BLOCKS, 32'd1000);
    send_idle_pct = 33;
    recv_idle_pct = 47;
    queue_random(80);
    hold_asked++;
    drain();
    queue_random(80);
    drain();

    write_reg(nhq_pkg::REG_STRIDE, 32'd0);
    write_reg(nhq_pkg::REG_NAMESPACE, 32'd0);
    write_reg(nhq_pkg::REG_BLOCKS, 32'd1);
    send_idle_pct = 47;
    recv_idle_pct = 33;
    queue_random(150);
    drain();

    write_reg(nhq_pkg::REG_STRIDE, 32'd15);
    write_reg(nhq_pkg::REG_NAMESPACE, 32'hFFFF_FFFF);
    write_reg(nhq_pkg::REG_BLOCKS, 32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(70);
    hold_asked++;
    queue_random(70);
    drain();

    if (errors == 0) begin
      $display("nvme_host_queue_pair_engine_unit test passed");
    end else begin
      $display("nvme_host_queue_pair_engine_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/nhq_pkg.sv
rtl/nhq_cfg.sv
rtl/nhq_core.sv
rtl/nhq_out.sv
rtl/nvme_host_queue_pair_engine_unit.sv
tb/sv/nvme_host_queue_pair_engine_unit_test.sv
